// ----- src/first_fit_free_run_finder_assert.svh -----
// Assertion macros for the finder controller (ffrf_ctrl).
// Needs clk and rst in the scope of the including module.
`ifndef FIRST_FIT_FREE_RUN_FINDER_ASSERT_SVH
`define FIRST_FIT_FREE_RUN_FINDER_ASSERT_SVH

// same-cycle implication
`define FFRF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("finder assertion failed");

// next-cycle implication
`define FFRF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("finder assertion failed");

`endif

// ----- src/ffrf_pkg.sv -----
// Shared types and codes for the first-fit free run finder.
// No dependencies.
`default_nettype none
package ffrf_pkg;
  localparam int KEY_W = 10;
  localparam int LEN_W = 10;
  localparam int OUT_W = 11;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_ERASE  = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  // spare code, ignored by the block
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN
  } state_t;
endpackage
`default_nettype wire

// ----- src/ffrf_bitmap.sv -----
// Occupancy bitmap: one write port, one registered read port.
// No package dependencies.
`default_nettype none
module ffrf_bitmap #(
  parameter int POSITIONS = 1024,
  parameter int AW = $clog2(POSITIONS)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic          wdata,
  input  wire logic [AW-1:0] raddr,
  output logic               rdata
);
  logic mem [POSITIONS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- src/ffrf_ctrl.sv -----
// Sequencer and bit-serial run scanner for the finder.
// Uses ffrf_pkg and the assertion macro header.
`default_nettype none
`include "first_fit_free_run_finder_assert.svh"
module ffrf_ctrl #(
  parameter int POSITIONS = 1024,
  parameter int AW = $clog2(POSITIONS)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [1:0]                  cmd,
  input  wire logic [ffrf_pkg::KEY_W-1:0]  key,
  input  wire logic [ffrf_pkg::LEN_W-1:0]  run_length,
  output logic                             busy,
  output logic                             done,
  output logic [ffrf_pkg::OUT_W-1:0]       run_start,
  output logic                             mem_we,
  output logic [AW-1:0]                    mem_waddr,
  output logic                             mem_wdata,
  output logic [AW-1:0]                    mem_raddr,
  input  wire logic                        mem_rdata
);
  localparam logic [AW-1:0] LAST = AW'(POSITIONS - 1);

  ffrf_pkg::state_t state, state_next;
  logic [AW-1:0] scan_idx;
  logic [AW-1:0] run_begin;
  logic [ffrf_pkg::LEN_W-1:0] len_q;
  logic accept, key_ok, is_last, found;
  logic [AW-1:0] key_idx;

  assign accept  = start && !busy;
  assign key_ok  = (key != '0) && (32'(key) < 32'(POSITIONS));
  assign key_idx = AW'(32'(key) - 32'd1);
  assign is_last = (scan_idx == LAST);
  // top cell is always free, so reaching it means we are in the tail
  assign found   = (len_q == '0) || is_last ||
                   (mem_rdata && (32'(scan_idx - run_begin) >= 32'(len_q)));

  always_comb begin
    state_next = state;
    unique case (state)
      ffrf_pkg::ST_CLEAR: if (is_last) state_next = ffrf_pkg::ST_IDLE;
      ffrf_pkg::ST_IDLE:  if (accept && cmd == ffrf_pkg::CMD_QUERY)
                            state_next = ffrf_pkg::ST_SCAN;
      ffrf_pkg::ST_SCAN:  if (found) state_next = ffrf_pkg::ST_IDLE;
      default:            state_next = ffrf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state != ffrf_pkg::ST_IDLE);
    mem_we    = 1'b0;
    mem_waddr = key_idx;
    mem_wdata = (cmd == ffrf_pkg::CMD_INSERT);
    mem_raddr = '0;
    unique case (state)
      ffrf_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = scan_idx;
        mem_wdata = 1'b0;
      end
      ffrf_pkg::ST_IDLE: begin
        // rewriting the same value covers duplicate insert / absent erase
        mem_we = accept && key_ok &&
                 (cmd == ffrf_pkg::CMD_INSERT || cmd == ffrf_pkg::CMD_ERASE);
      end
      ffrf_pkg::ST_SCAN: mem_raddr = scan_idx + AW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ffrf_pkg::ST_CLEAR;
      scan_idx <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ffrf_pkg::ST_SCAN) && found;
      unique case (state)
        ffrf_pkg::ST_CLEAR: scan_idx <= scan_idx + AW'(1);
        ffrf_pkg::ST_IDLE: begin
          if (accept && cmd == ffrf_pkg::CMD_QUERY) begin
            scan_idx  <= '0;
            run_begin <= '0;
            len_q     <= run_length;
          end
        end
        ffrf_pkg::ST_SCAN: begin
          if (found) begin
            run_start <= ffrf_pkg::OUT_W'(32'(run_begin) + 32'd1);
          end else begin
            scan_idx <= scan_idx + AW'(1);
            if (mem_rdata) begin
              run_begin <= scan_idx + AW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  `FFRF_ASSERT_NXT(a_scan_done, state == ffrf_pkg::ST_SCAN && found, done && !busy)
  `FFRF_ASSERT_IMP(a_done_idle, done, state == ffrf_pkg::ST_IDLE)
  `FFRF_ASSERT_IMP(a_run_order, state == ffrf_pkg::ST_SCAN, run_begin <= scan_idx)
  `FFRF_ASSERT_NXT(a_query_busy, accept && cmd == ffrf_pkg::CMD_QUERY, busy && !done)
endmodule
`default_nettype wire

// ----- src/first_fit_free_run_finder.sv -----
// Top level of the first-fit free run finder.
// Instantiates ffrf_ctrl and ffrf_bitmap; uses ffrf_pkg.
//
// Usage: a command word (cmd, key, run_length) is taken when start is high
// and busy is low. Insert (0) and erase (1) write the bitmap and give no
// result; busy stays low. Duplicate inserts, erases of free keys, key zero,
// keys at or above POSITIONS and the unused command are ignored.
// Query (2) scans the occupancy bitmap one position per cycle, tracking the
// start of the current free run; the run ending at an occupied position that
// is at least run_length long, or the free tail, gives the answer.
// A query keeps busy high while the scan runs from position 0 up to the
// occupied position that closes the chosen run, or up to the top position
// for the tail. The result is registered and shows in the cycle after the
// last scan position; the next word can be taken in the result cycle. The
// one bitmap read per cycle sets the scan rate. The result appears on
// run_start with done high for exactly one cycle; the receiver cannot stall
// it. Run length zero answers 1 with the scan ending at position 0.
// After reset the block clears every bitmap position with busy high, then
// accepts commands.
`default_nettype none
module first_fit_free_run_finder #(
  parameter int POSITIONS = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  cmd,
  input  wire logic [ffrf_pkg::KEY_W-1:0]  key,
  input  wire logic [ffrf_pkg::LEN_W-1:0]  run_length,
  output logic                             done,
  output logic [ffrf_pkg::OUT_W-1:0]       run_start
);
  localparam int AW = $clog2(POSITIONS);

  logic          mem_we, mem_wdata, mem_rdata;
  logic [AW-1:0] mem_waddr, mem_raddr;

  ffrf_ctrl #(.POSITIONS(POSITIONS), .AW(AW)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .cmd        (cmd),
    .key        (key),
    .run_length (run_length),
    .busy       (busy),
    .done       (done),
    .run_start  (run_start),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  ffrf_bitmap #(.POSITIONS(POSITIONS), .AW(AW)) u_bitmap (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );
endmodule
`default_nettype wire
